FILE: rtl/wahenc_pkg.sv
// Shared types and constants for the WAH bitmap append encoder.
package wahenc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_W       = 31;

    typedef enum logic [1:0] {
        MODE_LIT   = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_FLUSH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_state;

    typedef struct packed {
        logic accept;
        logic fill_step;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic fill_pend;
        logic fill_last;
        logic held_valid;
    } t_stat;

endpackage

FILE: rtl/wahenc_ctrl.sv
// Controller state machine: input handshake and fill word sequencing.
module wahenc_ctrl
    import wahenc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.fill_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = i_stat.slot_free;
                o_cmd.accept = i_valid && i_stat.slot_free;
                if (o_cmd.accept && i_stat.fill_pend) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = i_stat.slot_free;
                if (i_stat.slot_free && i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/wahenc_dp.sv
// Datapath: held word, remaining fill count and output register.
module wahenc_dp
    import wahenc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [1:0]           i_mode,
    input  logic [FIELD_W-1:0]   i_literal_bits,
    input  logic [FIELD_W-1:0]   i_fill_count,
    input  logic                 i_fill_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_code_word,
    output logic                 o_last_of_item,
    output logic                 o_end_of_bitmap
);

    localparam int CW = WORD_BITS - 2;
    localparam int LW = WORD_BITS - 1;
    localparam int SW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

    localparam logic [SW-1:0]        CNT_MAX = SW'({CW{1'b1}});
    localparam logic [WORD_BITS-1:0] LIT_ONE = {1'b0, {LW{1'b1}}};

    logic [WORD_BITS-1:0] r_held, n_held;
    logic                 r_hv, n_hv;
    logic [FIELD_W-1:0]   r_n, n_n;
    logic                 r_bit, n_bit;
    logic                 r_ov;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_last, r_end;

    logic                 emit, e_last, e_end;
    logic [LW-1:0]        lit_in, lit;
    logic                 zfill_open, ofill_open, fill_open;
    logic [SW-1:0]        sum, cnt_ext, rem, n_ext, take;
    logic                 do_lit;

    always_comb begin
        lit_in = '0;
        for (int i = 0; i < LW; i++) begin
            if (i < FIELD_W) begin
                lit_in[i] = i_literal_bits[i];
            end
        end
    end

    assign zfill_open = r_held[WORD_BITS-1] && !r_held[WORD_BITS-2]
                        && (r_held[CW-1:0] != {CW{1'b1}});
    assign ofill_open = r_held[WORD_BITS-1] && r_held[WORD_BITS-2]
                        && (r_held[CW-1:0] != {CW{1'b1}});
    assign fill_open  = i_fill_value ? ofill_open : zfill_open;

    assign cnt_ext = SW'(i_fill_count);
    assign sum     = SW'(r_held[CW-1:0]) + cnt_ext;
    assign n_ext   = SW'(r_n);
    assign take    = (n_ext > CNT_MAX) ? CNT_MAX : n_ext;

    always_comb begin
        if (r_hv && fill_open) begin
            rem = (sum > CNT_MAX) ? (sum - CNT_MAX) : '0;
        end else begin
            rem = cnt_ext;
        end
    end

    assign do_lit = (i_mode == MODE_LIT)
                    || (i_mode == MODE_FILL && r_hv && i_fill_count == FIELD_W'(1));
    assign lit    = (i_mode == MODE_LIT) ? lit_in : {LW{i_fill_value}};

    assign o_stat.slot_free  = !r_ov || i_ready;
    assign o_stat.fill_pend  = (i_mode == MODE_FILL) && !do_lit && (rem != '0);
    assign o_stat.fill_last  = (n_ext <= CNT_MAX);
    assign o_stat.held_valid = r_hv;

    always_comb begin
        n_held = r_held;
        n_hv   = r_hv;
        n_n    = r_n;
        n_bit  = r_bit;
        emit   = 1'b0;
        e_last = 1'b1;
        e_end  = 1'b0;
        if (i_cmd.accept) begin
            if (do_lit) begin
                if (!r_hv) begin
                    n_held = {1'b0, lit};
                    n_hv   = 1'b1;
                end else if (lit == '0 && r_held == '0) begin
                    n_held = {2'b10, CW'(2)};
                end else if (lit == '0 && zfill_open) begin
                    n_held = r_held + WORD_BITS'(1);
                end else if (lit == '1 && r_held == LIT_ONE) begin
                    n_held = {2'b11, CW'(2)};
                end else if (lit == '1 && ofill_open) begin
                    n_held = r_held + WORD_BITS'(1);
                end else begin
                    emit   = 1'b1;
                    n_held = {1'b0, lit};
                end
            end else begin
                case (i_mode)
                    MODE_FILL: begin
                        n_bit = i_fill_value;
                        n_n   = FIELD_W'(rem);
                        if (r_hv && fill_open) begin
                            n_held = {r_held[WORD_BITS-1:WORD_BITS-2],
                                      (sum > CNT_MAX) ? {CW{1'b1}} : sum[CW-1:0]};
                        end
                    end
                    MODE_FLUSH: begin
                        if (r_hv) begin
                            emit   = 1'b1;
                            e_end  = 1'b1;
                            n_held = '0;
                            n_hv   = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.fill_step) begin
            n_held = {1'b1, r_bit, take[CW-1:0]};
            n_hv   = 1'b1;
            n_n    = r_n - FIELD_W'(take);
            emit   = r_hv;
            e_last = o_stat.fill_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_hv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_held <= n_held;
            r_hv   <= n_hv;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_bit <= n_bit;
        if (emit) begin
            r_word <= r_held;
            r_last <= e_last;
            r_end  <= e_end;
        end
    end

    assign o_valid         = r_ov;
    assign o_code_word     = r_word;
    assign o_last_of_item  = r_last;
    assign o_end_of_bitmap = r_end;

endmodule

FILE: rtl/wah_bitmap_append_encoder_core.sv
// Top level of the WAH bitmap append encoder: controller plus datapath.
// Compresses literal groups and fill runs into WORD_BITS-bit WAH code words, holding back the
// newest word so later items can merge into it; a flush sends it out marked end_of_bitmap.
// A literal, a flush, or a fill that merges into the held word is done when its beat is
// accepted. A fill run that needs new fill words is accepted first; the controller then
// stays in S_FILL and makes fill words of up to 2^(WORD_BITS-2)-1 groups each. The single
// output register sets the pace further: while a word waits there untaken, nothing advances.
module wah_bitmap_append_encoder_core
    import wahenc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [FIELD_W-1:0]   i_literal_bits,
    input  logic [FIELD_W-1:0]   i_fill_count,
    input  logic                 i_fill_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_code_word,
    output logic                 o_last_of_item,
    output logic                 o_end_of_bitmap
);

    t_cmd  cmd;
    t_stat stat;

    wahenc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wahenc_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_literal_bits  (i_literal_bits),
        .i_fill_count    (i_fill_count),
        .i_fill_value    (i_fill_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_code_word     (o_code_word),
        .o_last_of_item  (o_last_of_item),
        .o_end_of_bitmap (o_end_of_bitmap)
    );

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_bitmap |-> o_last_of_item)
        else $error("end of bitmap beat without last_of_item");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode == MODE_FLUSH |=> !stat.held_valid)
        else $error("held word survives a flush");

    a_lit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode == MODE_LIT |=> stat.held_valid)
        else $error("literal left the stream empty");
`endif

endmodule

FILE: tb/sv/wah_bitmap_append_encoder_core_test.sv
// Testbench for the WAH bitmap append encoder: directed table, random beats, self-checking.
module wah_bitmap_append_encoder_core_test;
    import wahenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          W           = WORD_BITS_DEF;
    localparam logic [1:0]  MODE_RSVD   = 2'd3;
    localparam logic [31:0] CNT_MAX     = 32'h3fff_ffff;
    localparam logic [31:0] ZERO_FILL   = 32'h8000_0000;
    localparam logic [31:0] ONE_FILL    = 32'hc000_0000;
    localparam logic [31:0] ONES_LIT    = 32'h7fff_ffff;
    localparam int          STALL_LIMIT = 1000;
    localparam int          RAND_BEATS  = 204;

    typedef struct {
        logic [1:0]  mode;
        logic [30:0] lit;
        logic [30:0] cnt;
        logic        val;
        int          typed_n;
        logic [31:0] typed_w;
    } t_row;

    typedef struct packed {
        logic [W-1:0] word;
        logic         last;
        logic         eob;
    } t_wah_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_mode = MODE_LIT;
    logic [FIELD_W-1:0]   i_literal_bits = '0;
    logic [FIELD_W-1:0]   i_fill_count = '0;
    logic                 i_fill_value = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [W-1:0]         o_code_word;
    logic                 o_last_of_item;
    logic                 o_end_of_bitmap;

    wah_bitmap_append_encoder_core #(.WORD_BITS(W)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_literal_bits (i_literal_bits),
        .i_fill_count   (i_fill_count),
        .i_fill_value   (i_fill_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_word    (o_code_word),
        .o_last_of_item (o_last_of_item),
        .o_end_of_bitmap(o_end_of_bitmap)
    );

    always #4 i_clk = ~i_clk;

    // Encoder image: the word held back and whether the stream is open.
    logic [31:0] held_word = '0;
    logic        held_full = 1'b0;
    t_wah_out    beat_words[$];
    t_wah_out    wah_words_due[$];

    int          tx_idle_pct = 33;
    int          rx_idle_pct = 45;
    int          cur_typed_n = -1;
    logic [31:0] cur_typed_w = '0;
    int          n_bad = 0;
    int          stuck_cycles = 0;
    int          n_lit = 0, n_fill = 0, n_flush = 0, n_rsvd = 0;
    int          n_words = 0, n_eob = 0;
    bit          moved;
    t_row        dir_rows[$];

    function automatic bit fill_open(logic [31:0] w, logic [31:0] base);
        return w[31:30] == base[31:30] && w[29:0] != CNT_MAX[29:0];
    endfunction

    function void wah_push_word(logic [31:0] w);
        if (held_full) beat_words.push_back('{held_word, 1'b0, 1'b0});
        held_word = w;
        held_full = 1'b1;
    endfunction

    function void wah_put_literal(logic [31:0] lit);
        if (!held_full) begin
            wah_push_word(lit);
        end else if (lit == 32'd0) begin
            if (held_word == 32'd0) held_word = ZERO_FILL + 32'd2;
            else if (fill_open(held_word, ZERO_FILL)) held_word = held_word + 32'd1;
            else wah_push_word(lit);
        end else if (lit == ONES_LIT) begin
            if (held_word == ONES_LIT) held_word = ONE_FILL + 32'd2;
            else if (fill_open(held_word, ONE_FILL)) held_word = held_word + 32'd1;
            else wah_push_word(lit);
        end else begin
            wah_push_word(lit);
        end
    endfunction

    function void wah_fold_beat(logic [1:0] mode, logic [30:0] lit, logic [30:0] cnt,
                                logic val);
        logic [31:0] base;
        logic [31:0] left;
        logic [31:0] room;
        logic [31:0] take;
        beat_words.delete();
        base = val ? ONE_FILL : ZERO_FILL;
        left = {1'b0, cnt};
        if (mode == MODE_LIT) begin
            wah_put_literal({1'b0, lit});
        end else if (mode == MODE_FILL && left != 0) begin
            if (held_full && left == 32'd1) begin
                wah_put_literal(val ? ONES_LIT : 32'd0);
            end else begin
                if (held_full && fill_open(held_word, base)) begin
                    room = CNT_MAX - {2'b00, held_word[29:0]};
                    take = (room < left) ? room : left;
                    held_word = held_word + take;
                    left = left - take;
                end
                while (left != 0) begin
                    take = (left < CNT_MAX) ? left : CNT_MAX;
                    wah_push_word(base + take);
                    left = left - take;
                end
            end
        end else if (mode == MODE_FLUSH && held_full) begin
            beat_words.push_back('{held_word, 1'b0, 1'b1});
            held_word = '0;
            held_full = 1'b0;
        end
        if (beat_words.size() != 0) beat_words[beat_words.size()-1].last = 1'b1;
    endfunction

    function automatic t_row mk(logic [1:0] m, logic [30:0] l, logic [30:0] c, logic v,
                                int tn, logic [31:0] tw);
        t_row r;
        r.mode = m;
        r.lit = l;
        r.cnt = c;
        r.val = v;
        r.typed_n = tn;
        r.typed_w = tw;
        return r;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int   pick;
        int   sub;
        r = mk(MODE_LIT, 31'($urandom), 31'($urandom), 1'($urandom_range(1)), -1, '0);
        pick = $urandom_range(99);
        sub = $urandom_range(9);
        if (pick < 50) begin
            if (sub < 3) r.lit = '0;
            else if (sub < 6) r.lit = '1;
            else if (sub == 6) r.lit = 31'd1 << $urandom_range(30);
            else if (sub == 7) r.lit = ~(31'd1 << $urandom_range(30));
        end else if (pick < 85) begin
            r.mode = MODE_FILL;
            if (sub == 0) r.cnt = '0;
            else if (sub < 4) r.cnt = 31'd1;
            else if (sub < 7) r.cnt = 31'($urandom_range(6, 2));
            else if (sub == 7) r.cnt = CNT_MAX[30:0] - 31'($urandom_range(3));
            else if (sub == 8) r.cnt = CNT_MAX[30:0] + 31'($urandom_range(3));
        end else if (pick < 96) begin
            r.mode = MODE_FLUSH;
        end else begin
            r.mode = MODE_RSVD;
        end
        return r;
    endfunction

    task automatic send_beat(input t_row r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= r.mode;
        i_literal_bits <= r.lit;
        i_fill_count   <= r.cnt;
        i_fill_value   <= r.val;
        cur_typed_n    = r.typed_n;
        cur_typed_w    = r.typed_w;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && o_ready) begin
                moved = 1'b1;
                case (i_mode)
                    MODE_LIT:   n_lit++;
                    MODE_FILL:  n_fill++;
                    MODE_FLUSH: n_flush++;
                    default:    n_rsvd++;
                endcase
                wah_fold_beat(i_mode, i_literal_bits, i_fill_count, i_fill_value);
                if (cur_typed_n == 1)
                    wah_words_due.push_back('{cur_typed_w, 1'b1, i_mode == MODE_FLUSH});
                else if (cur_typed_n < 0)
                    foreach (beat_words[k]) wah_words_due.push_back(beat_words[k]);
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                n_words++;
                if (o_end_of_bitmap) n_eob++;
                if (wah_words_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: unexpected word %h last %b eob %b", $realtime,
                                 o_code_word, o_last_of_item, o_end_of_bitmap);
                end else begin
                    if (o_code_word !== wah_words_due[0].word ||
                        o_last_of_item !== wah_words_due[0].last ||
                        o_end_of_bitmap !== wah_words_due[0].eob) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("%0t: expected %h last %b eob %b, got %h last %b eob %b",
                                     $realtime, wah_words_due[0].word, wah_words_due[0].last,
                                     wah_words_due[0].eob, o_code_word, o_last_of_item,
                                     o_end_of_bitmap);
                    end
                    void'(wah_words_due.pop_front());
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        dir_rows.push_back(mk(MODE_FLUSH, '0, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_RSVD, '1, '1, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_FILL, '1, '0, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '1, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '1, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd1, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd5, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_FLUSH, '0, '0, 1'b0, 1, 32'hc000_0008));
        dir_rows.push_back(mk(MODE_LIT, '0, '1, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '0, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '0, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, 31'h5555_5555, '0, 1'b0, 1, 32'h8000_0003));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd1, 1'b0, 1, 32'h5555_5555));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd1, 1'b1, 1, 32'h0000_0000));
        dir_rows.push_back(mk(MODE_FILL, '0, '1, 1'b1, -1, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, '1, 1'b0, -1, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd2, 1'b0, -1, '0));
        dir_rows.push_back(mk(MODE_FLUSH, '0, '0, 1'b0, -1, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, CNT_MAX[30:0], 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '0, '0, 1'b0, 1, 32'hbfff_ffff));
        dir_rows.push_back(mk(MODE_FILL, '0, CNT_MAX[30:0] - 31'd1, 1'b0, 1, 32'h0));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd5, 1'b0, -1, '0));
        dir_rows.push_back(mk(MODE_FLUSH, '0, '0, 1'b0, -1, '0));
        dir_rows.push_back(mk(MODE_FILL, '0, 31'd1, 1'b1, 0, '0));
        dir_rows.push_back(mk(MODE_LIT, '1, '0, 1'b0, 0, '0));
        dir_rows.push_back(mk(MODE_FLUSH, '0, '0, 1'b0, 1, 32'hc000_0002));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_beat(dir_rows[k]);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 45 : 0;
            rx_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < RAND_BEATS / 3; k++) send_beat(rand_row());
        end
        i_valid <= 1'b0;

        while (wah_words_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        n_bad += wah_words_due.size();

        $display("beats in: %0d literal, %0d fill, %0d flush, %0d reserved mode",
                 n_lit, n_fill, n_flush, n_rsvd);
        $display("code words checked: %0d, of them %0d closing a bitmap, mismatches: %0d",
                 n_words, n_eob, n_bad);
        if (n_bad == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wahenc_pkg.sv
rtl/wahenc_ctrl.sv
rtl/wahenc_dp.sv
rtl/wah_bitmap_append_encoder_core.sv
tb/sv/wah_bitmap_append_encoder_core_test.sv
